>>> rtl/ddsc_pkg.sv
// shared types, constants and register codes of the speed command unit
`default_nettype none

package ddsc_pkg;

   localparam int TICK_PHASES = 6;
   localparam int DIGIT_COUNT = 3;
   localparam int STORE_DEPTH = 3;
   localparam int PHASE_W     = $clog2(TICK_PHASES);
   localparam int COUNT_W     = PHASE_W + 1;
   localparam int STORE_IDX_W = 2;

   localparam int VEL_GAIN_W   = 16;
   localparam int OMEGA_GAIN_W = 18;
   localparam int FRAC_W       = 16;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 18;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_VEL_GAIN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OMEGA_GAIN = 2'd1;

   localparam logic [VEL_GAIN_W-1:0]   VEL_GAIN_RESET   = 16'd37334;
   localparam logic [OMEGA_GAIN_W-1:0] OMEGA_GAIN_RESET = 18'd102145;

   // tick phases with an action
   localparam logic [COUNT_W-1:0] PH_RIGHT = COUNT_W'(1);
   localparam logic [COUNT_W-1:0] PH_LEFT  = COUNT_W'(2);
   localparam logic [COUNT_W-1:0] PH_CALC  = COUNT_W'(3);
   localparam logic [COUNT_W-1:0] PH_SEND  = COUNT_W'(4);
   localparam logic [COUNT_W-1:0] PH_LAST  = COUNT_W'(TICK_PHASES);

   // sample_taken codes
   localparam logic [1:0] TAKEN_NONE  = 2'd0;
   localparam logic [1:0] TAKEN_RIGHT = 2'd1;
   localparam logic [1:0] TAKEN_LEFT  = 2'd2;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [7:0] CHAR_A    = 8'h41;
   localparam logic [7:0] CHAR_B    = 8'h42;
   localparam logic [7:0] REF_RESET = 8'd100;

   localparam logic [7:0] STORE_RESET_0 = 8'h31;
   localparam logic [7:0] STORE_RESET_1 = 8'h38;
   localparam logic [7:0] STORE_RESET_2 = 8'h30;

   localparam logic [7:0] SAT_MAX = 8'd255;

   // classified item between front and back
   typedef struct packed {
      logic       is_tick;
      logic       is_digit;
      logic       is_arm_left;
      logic       is_arm_right;
      logic [7:0] ch;
      logic [7:0] sample;
   } ddsc_item_type;

   typedef struct packed {
      logic [7:0] velocity;
      logic [7:0] turn_rate;
      logic       turn_dir;
      logic [7:0] ref_left_out;
      logic [7:0] ref_right_out;
      logic       ref_send;
      logic [1:0] sample_taken;
      logic [2:0] indicators;
   } ddsc_result_type;

endpackage

`default_nettype wire

>>> rtl/ddsc_if.sv
// handshake channel interfaces: input items, result items, register writes
`default_nettype none

interface ddsc_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] rx_byte;
   logic [7:0] wheel_sample;

   modport source (output valid, output mode, output rx_byte, output wheel_sample,
                   input ready);
   modport sink   (input valid, input mode, input rx_byte, input wheel_sample,
                   output ready);
endinterface

interface ddsc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] velocity;
   logic [7:0] turn_rate;
   logic       turn_dir;
   logic [7:0] ref_left_out;
   logic [7:0] ref_right_out;
   logic       ref_send;
   logic [1:0] sample_taken;
   logic [2:0] indicators;

   modport source (output valid, output velocity, output turn_rate, output turn_dir,
                   output ref_left_out, output ref_right_out, output ref_send,
                   output sample_taken, output indicators, input ready);
   modport sink   (input valid, input velocity, input turn_rate, input turn_dir,
                   input ref_left_out, input ref_right_out, input ref_send,
                   input sample_taken, input indicators, output ready);
endinterface

interface ddsc_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [17:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/diff_drive_speed_command_unit.sv
// speed command unit top level: front end, item queue, back end
// an accepted item passes through the queue, then the back end's result register
// throughput: one item per cycle while no result waits or the result is taken
// the two-entry queue lets the input side keep going while a result is held
// reset: references 100, digit store "180", gains at their defaults, phase 0,
// queue empty and no result pending
`default_nettype none

module diff_drive_speed_command_unit
   import ddsc_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   ddsc_req_if.sink   req_chan,
   ddsc_rsp_if.source rsp_chan,
   ddsc_csr_if.sink   csr_chan
);

   logic          push;
   logic          pop;
   logic          queue_full;
   logic          head_valid;
   ddsc_item_type push_item;
   ddsc_item_type head;

   ddsc_front u_front (
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   ddsc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (head_valid),
      .head      (head)
   );

   ddsc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .csr_chan   (csr_chan),
      .rsp_chan   (rsp_chan)
   );

endmodule

`default_nettype wire

>>> rtl/ddsc_front.sv
// front end: accepts input items and classifies them for the back end
`default_nettype none

module ddsc_front
   import ddsc_pkg::*;
(
   ddsc_req_if.sink      req_chan,
   input  wire logic     queue_full,
   output logic          push,
   output ddsc_item_type push_item
);

   logic is_char;

   assign req_chan.ready = !queue_full;
   assign push           = req_chan.valid && !queue_full;
   assign is_char        = !req_chan.mode;

   always_comb begin
      push_item.is_tick      = req_chan.mode;
      push_item.is_digit     = is_char && (req_chan.rx_byte >= CHAR_ZERO)
                               && (req_chan.rx_byte <= CHAR_NINE);
      push_item.is_arm_left  = is_char && (req_chan.rx_byte == CHAR_A);
      push_item.is_arm_right = is_char && (req_chan.rx_byte == CHAR_B);
      push_item.ch           = req_chan.rx_byte;
      push_item.sample       = req_chan.wheel_sample;
   end

endmodule

`default_nettype wire

>>> rtl/ddsc_queue.sv
// short item queue between the front and back ends
`default_nettype none

module ddsc_queue
   import ddsc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire ddsc_item_type push_item,
   input  wire logic          pop,
   output logic               full,
   output logic               not_empty,
   output ddsc_item_type      head
);

   ddsc_item_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]    count_ff, count_in;

   function automatic logic [QUEUE_PTR_W-1:0] next_ptr(input logic [QUEUE_PTR_W-1:0] p);
      if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + QUEUE_PTR_W'(1);
   endfunction

   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

>>> rtl/ddsc_back.sv
// back end: command state, tick phases, speed arithmetic and result register
`default_nettype none

module ddsc_back
   import ddsc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          head_valid,
   input  wire ddsc_item_type head,
   output logic               pop,
   ddsc_csr_if.sink           csr_chan,
   ddsc_rsp_if.source         rsp_chan
);

   logic [VEL_GAIN_W-1:0]   vel_gain_ff;
   logic [OMEGA_GAIN_W-1:0] omega_gain_ff;

   logic [PHASE_W-1:0]      phase_ff, phase_in;
   logic [7:0]              speed_left_ff, speed_left_in;
   logic [7:0]              speed_right_ff, speed_right_in;
   logic [7:0]              ref_left_ff, ref_left_in;
   logic [7:0]              ref_right_ff, ref_right_in;
   logic [1:0]              armed_ff, armed_in;
   logic [1:0]              ready_ff, ready_in;
   logic [STORE_IDX_W-1:0]  idx_left_ff, idx_left_in;
   logic [STORE_IDX_W-1:0]  idx_right_ff, idx_right_in;
   logic [7:0]              store_ff [STORE_DEPTH];
   logic [7:0]              store_in [STORE_DEPTH];
   logic [7:0]              vel_hold_ff, vel_hold_in;
   logic [7:0]              turn_hold_ff, turn_hold_in;
   logic                    dir_hold_ff, dir_hold_in;
   logic [2:0]              led_ff, led_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   ddsc_result_type         rsp_data_ff, rsp_data_in;

   logic [COUNT_W-1:0]      cnt;
   logic [8:0]              speed_sum;
   logic [7:0]              speed_diff;
   logic [24:0]             vel_prod;
   logic [25:0]             turn_prod;
   logic [25:0]             vel_round;
   logic [26:0]             turn_round;
   logic [9:0]              vel_scaled;
   logic [10:0]             turn_scaled;
   logic [7:0]              vel_sat;
   logic [7:0]              turn_sat;
   logic [7:0]              store_value;
   logic [7:0]              digit_val [STORE_DEPTH];
   logic [STORE_IDX_W:0]    idx_next;

   assign pop            = head_valid && (!rsp_valid_ff || rsp_chan.ready);
   assign csr_chan.ready = 1'b1;

   // speed arithmetic, rounded half up and saturated
   always_comb begin
      speed_sum   = {1'b0, speed_right_ff} + {1'b0, speed_left_ff};
      speed_diff  = (speed_right_ff >= speed_left_ff) ? speed_right_ff - speed_left_ff
                                                      : speed_left_ff - speed_right_ff;
      vel_prod    = speed_sum * vel_gain_ff;
      turn_prod   = speed_diff * omega_gain_ff;
      vel_round   = {1'b0, vel_prod} + 26'(1 << (FRAC_W - 1));
      turn_round  = {1'b0, turn_prod} + 27'(1 << (FRAC_W - 1));
      vel_scaled  = vel_round[25:FRAC_W];
      turn_scaled = turn_round[26:FRAC_W];
      vel_sat     = (vel_scaled > 10'(SAT_MAX)) ? SAT_MAX : vel_scaled[7:0];
      turn_sat    = (turn_scaled > 11'(SAT_MAX)) ? SAT_MAX : turn_scaled[7:0];
   end

   // decimal value of the stored digits, mod 256
   always_comb begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
         digit_val[i] = store_ff[i] - CHAR_ZERO;
      end
      store_value = 8'(digit_val[0] * 8'd100) + 8'(digit_val[1] * 8'd10) + digit_val[2];
   end

   always_comb begin
      phase_in       = phase_ff;
      speed_left_in  = speed_left_ff;
      speed_right_in = speed_right_ff;
      ref_left_in    = ref_left_ff;
      ref_right_in   = ref_right_ff;
      armed_in       = armed_ff;
      ready_in       = ready_ff;
      idx_left_in    = idx_left_ff;
      idx_right_in   = idx_right_ff;
      store_in       = store_ff;
      vel_hold_in    = vel_hold_ff;
      turn_hold_in   = turn_hold_ff;
      dir_hold_in    = dir_hold_ff;
      led_in         = led_ff;
      cnt            = {1'b0, phase_ff} + COUNT_W'(1);
      idx_next       = '0;

      rsp_data_in.ref_send     = 1'b0;
      rsp_data_in.sample_taken = TAKEN_NONE;

      if (!head.is_tick) begin
         // left side takes the digit first, right side may overwrite it
         if (head.is_digit && armed_ff[0]) begin
            store_in[idx_left_ff] = head.ch;
            idx_next = {1'b0, idx_left_ff} + (STORE_IDX_W + 1)'(1);
            if (idx_next >= (STORE_IDX_W + 1)'(DIGIT_COUNT)) begin
               idx_left_in = '0;
               armed_in[0] = 1'b0;
               ready_in[0] = 1'b1;
            end else begin
               idx_left_in = idx_next[STORE_IDX_W-1:0];
            end
         end
         if (head.is_digit && armed_ff[1]) begin
            store_in[idx_right_ff] = head.ch;
            idx_next = {1'b0, idx_right_ff} + (STORE_IDX_W + 1)'(1);
            if (idx_next >= (STORE_IDX_W + 1)'(DIGIT_COUNT)) begin
               idx_right_in = '0;
               armed_in[1]  = 1'b0;
               ready_in[1]  = 1'b1;
            end else begin
               idx_right_in = idx_next[STORE_IDX_W-1:0];
            end
         end
         if (head.is_arm_right) begin
            armed_in[1] = 1'b1;
            led_in[0]   = ~led_ff[0];
         end
         if (head.is_arm_left) begin
            armed_in[0] = 1'b1;
            led_in[0]   = ~led_ff[0];
         end
      end else begin
         if (cnt == PH_RIGHT) begin
            rsp_data_in.sample_taken = TAKEN_RIGHT;
            if (head.sample != 8'd0 && head.sample != ref_right_ff) begin
               speed_right_in = head.sample;
            end
         end
         if (cnt == PH_LEFT) begin
            rsp_data_in.sample_taken = TAKEN_LEFT;
            if (head.sample != 8'd0 && head.sample != ref_left_ff) begin
               speed_left_in = head.sample;
            end
         end
         if (cnt == PH_CALC) begin
            vel_hold_in  = vel_sat;
            turn_hold_in = turn_sat;
            dir_hold_in  = (speed_right_ff < speed_left_ff);
         end
         if (cnt == PH_SEND) begin
            rsp_data_in.ref_send = 1'b1;
         end
         if (cnt >= PH_LAST) begin
            if (idx_left_ff == '0 && ready_ff[0]) begin
               ready_in[0] = 1'b0;
               ref_left_in = store_value;
               led_in[1]   = ~led_ff[1];
            end
            if (idx_right_ff == '0 && ready_ff[1]) begin
               ready_in[1]  = 1'b0;
               ref_right_in = store_value;
               led_in[2]    = ~led_ff[2];
            end
            phase_in = '0;
         end else begin
            phase_in = cnt[PHASE_W-1:0];
         end
      end

      rsp_data_in.velocity   = vel_hold_in;
      rsp_data_in.turn_rate  = turn_hold_in;
      rsp_data_in.turn_dir   = dir_hold_in;
      rsp_data_in.indicators = led_in;
      // a send shows the references as they were before any load
      if (rsp_data_in.ref_send) begin
         rsp_data_in.ref_left_out  = ref_left_ff;
         rsp_data_in.ref_right_out = ref_right_ff;
      end else begin
         rsp_data_in.ref_left_out  = ref_left_in;
         rsp_data_in.ref_right_out = ref_right_in;
      end

      rsp_valid_in = pop || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vel_gain_ff   <= VEL_GAIN_RESET;
         omega_gain_ff <= OMEGA_GAIN_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_VEL_GAIN:   vel_gain_ff   <= csr_chan.data[VEL_GAIN_W-1:0];
            CSR_OMEGA_GAIN: omega_gain_ff <= csr_chan.data[OMEGA_GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= '0;
         speed_left_ff  <= '0;
         speed_right_ff <= '0;
         ref_left_ff    <= REF_RESET;
         ref_right_ff   <= REF_RESET;
         armed_ff       <= '0;
         ready_ff       <= '0;
         idx_left_ff    <= '0;
         idx_right_ff   <= '0;
         store_ff[0]    <= STORE_RESET_0;
         store_ff[1]    <= STORE_RESET_1;
         store_ff[2]    <= STORE_RESET_2;
         vel_hold_ff    <= '0;
         turn_hold_ff   <= '0;
         dir_hold_ff    <= 1'b0;
         led_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            phase_ff       <= phase_in;
            speed_left_ff  <= speed_left_in;
            speed_right_ff <= speed_right_in;
            ref_left_ff    <= ref_left_in;
            ref_right_ff   <= ref_right_in;
            armed_ff       <= armed_in;
            ready_ff       <= ready_in;
            idx_left_ff    <= idx_left_in;
            idx_right_ff   <= idx_right_in;
            store_ff       <= store_in;
            vel_hold_ff    <= vel_hold_in;
            turn_hold_ff   <= turn_hold_in;
            dir_hold_ff    <= dir_hold_in;
            led_ff         <= led_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.velocity      = rsp_data_ff.velocity;
   assign rsp_chan.turn_rate     = rsp_data_ff.turn_rate;
   assign rsp_chan.turn_dir      = rsp_data_ff.turn_dir;
   assign rsp_chan.ref_left_out  = rsp_data_ff.ref_left_out;
   assign rsp_chan.ref_right_out = rsp_data_ff.ref_right_out;
   assign rsp_chan.ref_send      = rsp_data_ff.ref_send;
   assign rsp_chan.sample_taken  = rsp_data_ff.sample_taken;
   assign rsp_chan.indicators    = rsp_data_ff.indicators;

endmodule

`default_nettype wire
